FILE: rtl/core/sm3_pkg.sv
// sm3_pkg: shared constants and helper functions for the sm3 hash core
// holds round constants, reset chaining value and the permutation functions
// no dependencies

package sm3_pkg;

    typedef logic [31:0] t_word;

    // round constants for rounds 0..15 and 16..63
    localparam t_word T_LOW  = 32'h79CC4519;
    localparam t_word T_HIGH = 32'h7A879D8A;

    // reset values of the iv registers, word a first
    localparam t_word IV_RESET [8] = '{
        32'h3452666F, 32'h4914B2B0, 32'h859442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam int NUM_ROUNDS = 64;
    localparam int BLOCK_WORDS = 16;
    localparam int DIGEST_WORDS = 8;

    // left rotate, a zero amount returns the word unchanged
    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // rotated round constant for round j
    function automatic t_word t_rot(input logic [5:0] j);
        t_word base;
        base = (j[5:4] == 2'b00) ? T_LOW : T_HIGH;
        return rotl(base, j[4:0]);
    endfunction

endpackage

FILE: rtl/core/sm3_hash_core.sv
// sm3_hash_core: iterative sm3 hash engine, one compression round per cycle
// depends on sm3_pkg for constants and the permutation functions
// message words in on the slave stream, digest words out on the master stream
//
// usage
//   slave stream: one 32-bit big-endian word of the padded message per
//   transaction, tlast on the final word. software does all padding. every
//   16 words form a block; a final block cut short by tlast is zero filled.
//   master stream: eight digest words, word a first, tlast on the eighth.
//   config port: i_cfg_we writes iv register i_cfg_addr (words a..h). the
//   iv is loaded into the chaining value on the first word of each message.
// timing
//   words are taken one per cycle while a block fills. a full block (or a
//   tlast) starts the compression rounds on the shared round datapath,
//   during which tready is low, so no new word is taken while a block is
//   compressed. the chaining value update happens in the last round.
//   after the final block the digest is shown once its last round is done
//   and drains at one word per cycle while tready is high.
//   a stalled receiver holds the current digest word; no new message word is
//   taken until the eighth digest word has been accepted.
// reset
//   synchronous active-low reset returns to idle, clears the word and round
//   counters and restores the iv registers to their reset values.

module sm3_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] message_word
    input  logic        i_s_axis_tlast,   // message_end
    // digest stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] digest_word
    output logic        o_m_axis_tlast,   // digest_last
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_OUT
    } t_state;

    t_state         r_state;
    sm3_pkg::t_word r_iv [8];
    sm3_pkg::t_word r_cv [8];
    sm3_pkg::t_word r_wv [8];
    sm3_pkg::t_word r_w  [16];
    logic [3:0]     r_word_idx;
    logic [5:0]     r_round;
    logic [2:0]     r_out_cnt;
    logic           r_in_msg;
    logic           r_last_blk;

    logic           in_xact;
    logic           out_xact;
    logic           blk_full;

    // round datapath signals
    sm3_pkg::t_word a12, ss1, ss2, ff, gg, tt1, tt2, sum1, w_next;
    sm3_pkg::t_word n_wv [8];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = r_cv[0];
    assign o_m_axis_tlast  = (r_out_cnt == 3'(sm3_pkg::DIGEST_WORDS - 1));

    assign in_xact  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xact = o_m_axis_tvalid && i_m_axis_tready;
    assign blk_full = i_s_axis_tlast || (r_word_idx == 4'(sm3_pkg::BLOCK_WORDS - 1));

    // one compression round on the working variables
    always_comb begin
        a12  = sm3_pkg::rotl(r_wv[0], 5'd12);
        sum1 = a12 + r_wv[4] + sm3_pkg::t_rot(r_round);
        ss1  = sm3_pkg::rotl(sum1, 5'd7);
        ss2  = ss1 ^ a12;
        if (r_round[5:4] == 2'b00) begin
            ff = r_wv[0] ^ r_wv[1] ^ r_wv[2];
            gg = r_wv[4] ^ r_wv[5] ^ r_wv[6];
        end else begin
            ff = (r_wv[0] & r_wv[1]) | (r_wv[0] & r_wv[2]) | (r_wv[1] & r_wv[2]);
            gg = (r_wv[4] & r_wv[5]) | (~r_wv[4] & r_wv[6]);
        end
        tt1 = ff + r_wv[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_wv[7] + ss1 + r_w[0];
        n_wv[0] = tt1;
        n_wv[1] = r_wv[0];
        n_wv[2] = sm3_pkg::rotl(r_wv[1], 5'd9);
        n_wv[3] = r_wv[2];
        n_wv[4] = sm3_pkg::perm0(tt2);
        n_wv[5] = r_wv[4];
        n_wv[6] = sm3_pkg::rotl(r_wv[5], 5'd19);
        n_wv[7] = r_wv[6];
    end

    // message expansion: next word entering the 16-word window
    assign w_next = sm3_pkg::perm1(r_w[0] ^ r_w[7] ^ sm3_pkg::rotl(r_w[13], 5'd15))
                    ^ sm3_pkg::rotl(r_w[3], 5'd7) ^ r_w[10];

    // sequencer, counters, iv registers and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_word_idx <= '0;
            r_round    <= '0;
            r_out_cnt  <= '0;
            r_in_msg   <= 1'b0;
            r_last_blk <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_iv[i] <= sm3_pkg::IV_RESET[i];
            end
        end else begin
            if (i_cfg_we) begin
                r_iv[i_cfg_addr] <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xact) begin
                        // store the word, zero fill the rest on a short final block
                        for (int k = 0; k < sm3_pkg::BLOCK_WORDS; k++) begin
                            if (4'(k) == r_word_idx) begin
                                r_w[k] <= i_s_axis_tdata;
                            end else if (i_s_axis_tlast && (4'(k) > r_word_idx)) begin
                                r_w[k] <= '0;
                            end
                        end
                        // first word of a message loads the iv
                        if (!r_in_msg) begin
                            r_cv <= r_iv;
                        end
                        r_in_msg <= 1'b1;
                        if (blk_full) begin
                            if (r_in_msg) begin
                                r_wv <= r_cv;
                            end else begin
                                r_wv <= r_iv;
                            end
                            r_round    <= '0;
                            r_word_idx <= '0;
                            r_last_blk <= i_s_axis_tlast;
                            r_state    <= S_ROUND;
                        end else begin
                            r_word_idx <= r_word_idx + 4'd1;
                        end
                    end
                end
                S_ROUND: begin
                    r_wv <= n_wv;
                    for (int k = 0; k < sm3_pkg::BLOCK_WORDS - 1; k++) begin
                        r_w[k] <= r_w[k + 1];
                    end
                    r_w[sm3_pkg::BLOCK_WORDS - 1] <= w_next;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(sm3_pkg::NUM_ROUNDS - 1)) begin
                        // fold the round result into the chaining value
                        for (int i = 0; i < 8; i++) begin
                            r_cv[i] <= r_cv[i] ^ n_wv[i];
                        end
                        if (r_last_blk) begin
                            r_in_msg  <= 1'b0;
                            r_out_cnt <= '0;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    // digest drains from the chaining value, word a first
                    if (out_xact) begin
                        for (int i = 0; i < 7; i++) begin
                            r_cv[i] <= r_cv[i + 1];
                        end
                        r_out_cnt <= r_out_cnt + 3'd1;
                        if (o_m_axis_tlast) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sm3_chk.sv
// sm3_chk: port-level assertions for sm3_hash_core
// bound into sm3_hash_core; sees its ports only, no package dependency

module sm3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("digest transaction changed while stalled");

    // message words are never taken while a digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while digest pending");

    // the final message word starts compression, input closes
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=>
            !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("no compression after final word");

    // the eighth digest word ends the output burst
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=>
            !o_m_axis_tvalid && o_s_axis_tready)
        else $error("digest burst did not end on last word");

endmodule

bind sm3_hash_core sm3_chk u_sm3_chk (.*);

FILE: tb/sv/tb_sm3_hash_core.sv
// tb_sm3_hash_core: self-checking testbench for the sm3 hash core
// drives message words and iv writes, checks every digest word
// depends on sm3_pkg and sm3_hash_core
`timescale 1ns / 100ps

module tb_sm3_hash_core;

    // one expected digest transaction
    typedef struct packed {
        sm3_pkg::t_word word;
        logic           last;
    } t_digest;

    // iv settings stepped through between message phases
    typedef enum int {
        IV_ZEROS,
        IV_ONES,
        IV_RANDOM,
        IV_DEFAULT
    } t_iv_mode;

    localparam int DIR_COUNT = 23;
    // longest legal run without a transaction is the compression rounds plus the
    // iv pause, the end wait and sink stalls, so this leaves a wide margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS = 60;

    // directed messages: single zero and all-ones words, a short block,
    // a block ending exactly on its sixteenth word, a two-word message
    localparam sm3_pkg::t_word DIR_WORD [DIR_COUNT] = '{
        32'h00000000, 32'hFFFFFFFF,
        32'h61626380, 32'h00000000, 32'h00000018,
        32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
        32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
        32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
        32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
        32'h12345678, 32'h9ABCDEF0
    };
    localparam bit DIR_LAST [DIR_COUNT] = '{
        1'b1, 1'b1,
        1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b1
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;
    wire         o_m_axis_tlast;

    // predictor state
    sm3_pkg::t_word iv_shadow [8];
    sm3_pkg::t_word chain_val [8];
    sm3_pkg::t_word blk_words [16];
    int             word_pos;
    bit             in_msg;
    t_digest        digest_q [$];

    bit quiet = 1'b0;
    int errors = 0;
    int words_in = 0;
    int messages_in = 0;
    int digests_checked = 0;
    int iv_settings = 0;
    int stall_cycles = 0;

    sm3_hash_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),      // [31:0] message_word
        .i_s_axis_tlast  (s_last),      // message_end
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] digest_word
        .o_m_axis_tlast  (o_m_axis_tlast),  // digest_last
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic sm3_pkg::t_word rot_left(input sm3_pkg::t_word x, input int n);
        int k;
        k = n % 32;
        if (k == 0) return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic sm3_pkg::t_word mix_p0(input sm3_pkg::t_word x);
        return x ^ rot_left(x, 9) ^ rot_left(x, 17);
    endfunction

    function automatic sm3_pkg::t_word mix_p1(input sm3_pkg::t_word x);
        return x ^ rot_left(x, 15) ^ rot_left(x, 23);
    endfunction

    // expand the current block and run the 64 rounds into chain_val
    function automatic void compress_block();
        sm3_pkg::t_word w [68];
        sm3_pkg::t_word wp [64];
        sm3_pkg::t_word v [8];
        sm3_pkg::t_word a12, ss1, ss2, ff, gg, tt1, tt2, tc;
        int j;
        for (j = 0; j < 16; j++) w[j] = blk_words[j];
        for (j = 16; j < 68; j++)
            w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15))
                   ^ rot_left(w[j-13], 7) ^ w[j-6];
        for (j = 0; j < 64; j++) wp[j] = w[j] ^ w[j+4];
        v = chain_val;
        for (j = 0; j < 64; j++) begin
            tc  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
            a12 = rot_left(v[0], 12);
            ss1 = rot_left(a12 + v[4] + rot_left(tc, j % 32), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end else begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1 = ff + v[3] + ss2 + wp[j];
            tt2 = gg + v[7] + ss1 + w[j];
            v[3] = v[2];
            v[2] = rot_left(v[1], 9);
            v[1] = v[0];
            v[0] = tt1;
            v[7] = v[6];
            v[6] = rot_left(v[5], 19);
            v[5] = v[4];
            v[4] = mix_p0(tt2);
        end
        for (j = 0; j < 8; j++) chain_val[j] = chain_val[j] ^ v[j];
    endfunction

    // absorb one accepted message word, queue the digest on message end
    function automatic void absorb_word(input sm3_pkg::t_word word, input logic last);
        int k;
        if (!in_msg) begin
            chain_val = iv_shadow;
            in_msg = 1'b1;
        end
        blk_words[word_pos] = word;
        if (last) begin
            for (k = word_pos + 1; k < 16; k++) blk_words[k] = '0;
            compress_block();
            word_pos = 0;
            in_msg = 1'b0;
            for (k = 0; k < 8; k++) digest_q.push_back('{chain_val[k], k == 7});
        end else if (word_pos == 15) begin
            compress_block();
            word_pos = 0;
        end else begin
            word_pos++;
        end
    endfunction

    // monitor: predict on each message transaction, check each digest transaction
    always @(posedge i_clk) begin
        t_digest exp_d;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                absorb_word(s_data, s_last);
                words_in++;
                if (s_last) messages_in++;
            end
            if (o_m_axis_tvalid && m_ready) begin
                if (digest_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected digest transaction, got %08h last %0b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    exp_d = digest_q.pop_front();
                    digests_checked++;
                    if (o_m_axis_tdata !== exp_d.word) begin
                        errors++;
                        $display("%0t: digest word mismatch, expected %08h, got %08h",
                                 $time, exp_d.word, o_m_axis_tdata);
                    end
                    if (o_m_axis_tlast !== exp_d.last) begin
                        errors++;
                        $display("%0t: digest last mismatch, expected %0b, got %0b",
                                 $time, exp_d.last, o_m_axis_tlast);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d digest words outstanding",
                     $time, digest_q.size());
            $display("tb_sm3_hash_core: done, errors");
            $finish;
        end
    end

    // digest sink with random backpressure
    initial begin
        forever begin
            @(negedge i_clk);
            m_ready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    // one message transaction, with a random gap ahead of it
    task automatic send_word(input sm3_pkg::t_word word, input logic last);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        s_last  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random message, mostly short, some spanning two or three blocks
    task automatic send_message(output int len);
        int sel, k;
        sm3_pkg::t_word word;
        sel = $urandom_range(0, 99);
        if (sel < 70) len = $urandom_range(1, 16);
        else if (sel < 90) len = $urandom_range(17, 32);
        else len = $urandom_range(33, 48);
        for (k = 0; k < len; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) word = '0;
            else if (sel < 16) word = '1;
            else word = $urandom();
            send_word(word, k == len - 1);
        end
    endtask

    // wait for all digests, then let the core fall idle
    task automatic drain();
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // write all eight iv registers while the core is idle
    task automatic load_iv(input t_iv_mode mode);
        sm3_pkg::t_word v;
        int i;
        for (i = 0; i < 8; i++) begin
            case (mode)
                IV_ZEROS:   v = '0;
                IV_ONES:    v = '1;
                IV_DEFAULT: v = sm3_pkg::IV_RESET[i];
                default:    v = $urandom();
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= v;
            iv_shadow[i] = v;
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        iv_settings++;
    endtask

    // main sequence
    initial begin
        int i, len, phase_words;
        t_iv_mode modes [4];
        modes = '{IV_ZEROS, IV_ONES, IV_RANDOM, IV_DEFAULT};
        iv_shadow = sm3_pkg::IV_RESET;
        chain_val = sm3_pkg::IV_RESET;
        word_pos = 0;
        in_msg = 1'b0;
        iv_settings = 1;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed messages under the reset iv
        for (i = 0; i < DIR_COUNT; i++) send_word(DIR_WORD[i], DIR_LAST[i]);
        drain();

        // random messages under each iv setting; no idling under all ones
        for (i = 0; i < 4; i++) begin
            load_iv(modes[i]);
            quiet = (modes[i] == IV_ONES);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                send_message(len);
                phase_words += len;
            end
            drain();
        end
        quiet = 1'b0;
        repeat (100) @(negedge i_clk);

        $display("covered %0d message words in %0d messages over %0d iv settings",
                 words_in, messages_in, iv_settings);
        $display("checked %0d digest words, %0d mismatches", digests_checked, errors);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("tb_sm3_hash_core: done, clean");
        end else begin
            $display("tb_sm3_hash_core: done, errors");
        end
        $finish;
    end

endmodule

FILE: sm3_hash_core.f
rtl/core/sm3_pkg.sv
rtl/core/sm3_hash_core.sv
rtl/core/sm3_chk.sv
tb/sv/tb_sm3_hash_core.sv
